### design/kfc_pkg.sv
// ----------------------------------------------------------------------------
// kfc_pkg: shared types and constants for the keyword frequency counter
// Command codes, the stored item and result layouts, and the separator test.
// ----------------------------------------------------------------------------
package kfc_pkg;

  // Fixed field widths of the stream payload.
  localparam int CMD_W       = 2;
  localparam int SLOT_FW     = 4;
  localparam int POS_FW      = 4;
  localparam int BYTE_W      = 8;
  localparam int LEN_W       = 5;
  localparam int COUNT_OUT_W = 32;
  localparam int MSLOT_W     = 4;
  localparam int KCOUNT_W    = 5;

  // Word separators.
  localparam logic [BYTE_W-1:0] CHAR_SPACE   = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;

  typedef enum logic [CMD_W-1:0] {
    CMD_LOAD  = 2'd0,
    CMD_TEXT  = 2'd1,
    CMD_READ  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  // One input transaction as held in the input register.
  typedef struct packed {
    cmd_t               command;
    logic [SLOT_FW-1:0] slot;
    logic [POS_FW-1:0]  position;
    logic [BYTE_W-1:0]  byte_value;
    logic               final_char;
  } item_t;

  // One result transaction.
  typedef struct packed {
    logic [COUNT_OUT_W-1:0] count_value;
    logic                   word_matched;
    logic [MSLOT_W-1:0]     matched_slot;
  } result_t;

  function automatic logic is_separator(input logic [BYTE_W-1:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_NEWLINE);
  endfunction

endpackage

### design/kfc_ram.sv
// ----------------------------------------------------------------------------
// kfc_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered (read-first).
// ----------------------------------------------------------------------------
module kfc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                         wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; a read of the address being written sees old data.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

### design/kfc_kw_store.sv
// ----------------------------------------------------------------------------
// kfc_kw_store: keyword byte and length storage
// One RAM per slot holds the keyword bytes; every slot is read at the same
// character index each cycle. Lengths sit in flip-flops.
// ----------------------------------------------------------------------------
module kfc_kw_store
  import kfc_pkg::*;
#(
  parameter int KEYWORD_SLOTS   = 16,
  parameter int MAX_KEYWORD_LEN = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   fire,
  input  item_t                  item,
  input  logic [((MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1)-1:0] rd_addr,
  output logic [BYTE_W-1:0]      kw_byte [KEYWORD_SLOTS],
  output logic [LEN_W-1:0]       kw_len  [KEYWORD_SLOTS]
);

  localparam int ADDR_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

  logic                     load_ok;
  logic [ADDR_W-1:0]        wr_addr;
  logic [KEYWORD_SLOTS-1:0] wr_en;
  logic [KEYWORD_SLOTS-1:0] byp_hit;
  logic [BYTE_W-1:0]        byp_data;
  logic [BYTE_W-1:0]        ram_q [KEYWORD_SLOTS];

  // A load is taken only for a slot and position inside the table.
  assign load_ok = fire && (item.command == CMD_LOAD) &&
                   (int'(item.slot) < KEYWORD_SLOTS) &&
                   (int'(item.position) < MAX_KEYWORD_LEN);
  assign wr_addr = ADDR_W'(item.position);

  // Register the written byte so that a read of the same entry, issued with the write, sees it.
  always_ff @(posedge clk) begin
    byp_data <= item.byte_value;
  end

  for (genvar s = 0; s < KEYWORD_SLOTS; s++) begin : g_slot
    assign wr_en[s] = load_ok && (int'(item.slot) == s);

    kfc_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (MAX_KEYWORD_LEN)
    ) u_ram (
      .clk     (clk),
      .wr_en   (wr_en[s]),
      .wr_addr (wr_addr),
      .wr_data (item.byte_value),
      .rd_addr (rd_addr),
      .rd_data (ram_q[s])
    );

    // Write-to-read forwarding flag.
    always_ff @(posedge clk) begin
      if (rst) begin
        byp_hit[s] <= 1'b0;
      end else begin
        byp_hit[s] <= wr_en[s] && (wr_addr == rd_addr);
      end
    end

    assign kw_byte[s] = byp_hit[s] ? byp_data : ram_q[s];

    // Keyword length, set by the load that carries the last character.
    always_ff @(posedge clk) begin
      if (rst) begin
        kw_len[s] <= '0;
      end else if (wr_en[s] && item.final_char) begin
        kw_len[s] <= LEN_W'(item.position) + LEN_W'(1);
      end
    end
  end

endmodule

### design/kfc_matcher.sv
// ----------------------------------------------------------------------------
// kfc_matcher: word tracking, slot matching and per-slot counters
// Keeps the word position and one alive bit per slot, credits the lowest
// matching slot when a separator closes a word, and serves reads and clears.
// ----------------------------------------------------------------------------
module kfc_matcher
  import kfc_pkg::*;
#(
  parameter int KEYWORD_SLOTS   = 16,
  parameter int MAX_KEYWORD_LEN = 16,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                fire,
  input  item_t               item,
  input  logic [KCOUNT_W-1:0] keyword_count,
  input  logic [BYTE_W-1:0]   kw_byte [KEYWORD_SLOTS],
  input  logic [LEN_W-1:0]    kw_len  [KEYWORD_SLOTS],
  output logic [((MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1)-1:0] rd_addr,
  output result_t             res
);

  localparam int ADDR_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;
  localparam int WP_W   = $clog2(MAX_KEYWORD_LEN + 2);
  localparam int CMP_W  = (WP_W > LEN_W) ? WP_W : LEN_W;
  localparam int SLOT_W = (KEYWORD_SLOTS > 1) ? $clog2(KEYWORD_SLOTS) : 1;
  localparam logic [WP_W-1:0]        WP_FULL   = WP_W'(MAX_KEYWORD_LEN);
  localparam logic [WP_W-1:0]        WP_OVER   = WP_W'(MAX_KEYWORD_LEN + 1);
  localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

  logic [WP_W-1:0]          word_position, word_position_next;
  logic [KEYWORD_SLOTS-1:0] alive_mask, alive_mask_next;
  logic [COUNT_WIDTH-1:0]   counts [KEYWORD_SLOTS];
  logic [KEYWORD_SLOTS-1:0] in_use;
  logic [KEYWORD_SLOTS-1:0] cand;
  logic                     hit;
  logic [SLOT_W-1:0]        hit_idx;
  logic                     word_ok;
  logic                     credit;
  logic                     clear_all;

  // Slots in use and slots whose keyword equals the word so far.
  for (genvar s = 0; s < KEYWORD_SLOTS; s++) begin : g_cand
    assign in_use[s] = int'(keyword_count) > s;
    assign cand[s]   = in_use[s] && alive_mask[s] &&
                       (CMP_W'(kw_len[s]) == CMP_W'(word_position));
  end

  assign hit     = |cand;
  assign word_ok = (word_position != '0) && (word_position <= WP_FULL);

  // Lowest candidate slot.
  always_comb begin
    hit_idx = '0;
    for (int i = KEYWORD_SLOTS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        hit_idx = SLOT_W'(i);
      end
    end
  end

  // Command decode, next word state and the result.
  always_comb begin
    word_position_next = word_position;
    alive_mask_next    = alive_mask;
    credit             = 1'b0;
    clear_all          = 1'b0;
    res                = '0;
    if (fire) begin
      unique case (item.command)
        CMD_LOAD: begin
          credit = 1'b0;
        end
        CMD_TEXT: begin
          if (is_separator(item.byte_value)) begin
            if (word_ok && hit) begin
              credit           = 1'b1;
              res.word_matched = 1'b1;
              res.matched_slot = MSLOT_W'(hit_idx);
            end
            alive_mask_next    = '1;
            word_position_next = '0;
          end else if (word_position < WP_FULL) begin
            for (int s = 0; s < KEYWORD_SLOTS; s++) begin
              if ((CMP_W'(word_position) >= CMP_W'(kw_len[s])) ||
                  (kw_byte[s] != item.byte_value)) begin
                alive_mask_next[s] = 1'b0;
              end
            end
            word_position_next = word_position + WP_W'(1);
          end else begin
            alive_mask_next    = '0;
            word_position_next = WP_OVER;
          end
        end
        CMD_READ: begin
          if (int'(item.slot) < KEYWORD_SLOTS) begin
            res.count_value = COUNT_OUT_W'(counts[SLOT_W'(item.slot)]);
          end
        end
        CMD_CLEAR: begin
          clear_all = 1'b1;
        end
      endcase
    end
  end

  // Keyword bytes are fetched ahead at the next character index.
  assign rd_addr = ADDR_W'(word_position_next);

  // Word state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      word_position <= '0;
      alive_mask    <= '1;
    end else begin
      word_position <= word_position_next;
      alive_mask    <= alive_mask_next;
    end
  end

  // Saturating per-slot counters.
  for (genvar s = 0; s < KEYWORD_SLOTS; s++) begin : g_count
    always_ff @(posedge clk) begin
      if (rst) begin
        counts[s] <= '0;
      end else if (clear_all) begin
        counts[s] <= '0;
      end else if (credit && (int'(hit_idx) == s) && (counts[s] != COUNT_MAX)) begin
        counts[s] <= counts[s] + COUNT_WIDTH'(1);
      end
    end
  end

  // An empty word has every slot still alive.
  a_alive_at_start: assert property (@(posedge clk) disable iff (rst)
    (word_position == '0) |-> (&alive_mask))
    else $error("alive mask not full at word start");

  // The word position never runs past the over-long mark.
  a_wp_bound: assert property (@(posedge clk) disable iff (rst)
    word_position <= WP_OVER)
    else $error("word position out of range");

  // A credited slot holds a nonzero count afterwards.
  a_credit_counts: assert property (@(posedge clk) disable iff (rst)
    (fire && res.word_matched) |=> (counts[$past(hit_idx)] != '0))
    else $error("credited slot count is zero");

  // Only a separator byte reports a match.
  a_match_on_sep: assert property (@(posedge clk) disable iff (rst)
    (fire && res.word_matched) |->
      ((item.command == CMD_TEXT) && is_separator(item.byte_value)))
    else $error("match reported without a separator");

endmodule

### design/keyword_frequency_counter_unit.sv
// ----------------------------------------------------------------------------
// keyword_frequency_counter_unit: whole-word keyword counter for a byte stream
// Loads keywords into slots, splits text into words at space or newline,
// and counts exact matches per slot with saturating counters.
//
// Channel  Dir  Handshake        Payload
// cfg      in   cfg_valid/ready  cfg_data = keyword_count
// s        in   s_tvalid/tready  tdata = slot, position, byte_value;
//                                tuser = command; tlast = final_char
// m        out  m_tvalid/tready  tdata = count_value, matched_slot;
//                                tuser = word_matched
//
// One transaction is accepted per cycle while the result side is not stalled;
// its result passes through the input register, then the result register.
// The keyword byte RAMs are read ahead at the next character index, so the
// compare of each text byte does not wait on a RAM read.
// Reset clears lengths, counts and word state directly; no clearing pass.
// A stalled result holds in the result register while one more item waits
// in the input register.
// ----------------------------------------------------------------------------
module keyword_frequency_counter_unit
  import kfc_pkg::*;
#(
  parameter int KEYWORD_SLOTS   = 16,
  parameter int MAX_KEYWORD_LEN = 16,
  parameter int COUNT_WIDTH     = 32
) (
  input  logic                clk,
  input  logic                rst,
  // Configuration write channel
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [KCOUNT_W-1:0] cfg_data,
  // Input stream
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [15:0]         s_tdata,   // slot[3:0], position[7:4], byte_value[15:8]
  input  logic [CMD_W-1:0]    s_tuser,   // command[1:0]
  input  logic                s_tlast,
  // Result stream
  output logic                m_tvalid,
  input  logic                m_tready,
  output logic [39:0]         m_tdata,   // count_value[31:0], matched_slot[35:32], zero
  output logic                m_tuser    // word_matched
);

  localparam int ADDR_W = (MAX_KEYWORD_LEN > 1) ? $clog2(MAX_KEYWORD_LEN) : 1;

  logic [KCOUNT_W-1:0] kcount;
  logic                in_valid;
  item_t               in_item;
  logic                out_valid;
  result_t             out_res;
  result_t             res;
  logic                advance;
  logic                fire;
  logic [ADDR_W-1:0]   rd_addr;
  logic [BYTE_W-1:0]   kw_byte [KEYWORD_SLOTS];
  logic [LEN_W-1:0]    kw_len  [KEYWORD_SLOTS];

  // Configuration register is always writable.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      kcount <= '0;
    end else if (cfg_valid) begin
      kcount <= cfg_data;
    end
  end

  // Stage handshakes.
  assign advance  = !out_valid || m_tready;
  assign fire     = in_valid && advance;
  assign s_tready = !in_valid || advance;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_item.command    <= cmd_t'(s_tuser);
      in_item.slot       <= s_tdata[3:0];
      in_item.position   <= s_tdata[7:4];
      in_item.byte_value <= s_tdata[15:8];
      in_item.final_char <= s_tlast;
    end
  end

  kfc_kw_store #(
    .KEYWORD_SLOTS   (KEYWORD_SLOTS),
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN)
  ) u_store (
    .clk     (clk),
    .rst     (rst),
    .fire    (fire),
    .item    (in_item),
    .rd_addr (rd_addr),
    .kw_byte (kw_byte),
    .kw_len  (kw_len)
  );

  kfc_matcher #(
    .KEYWORD_SLOTS   (KEYWORD_SLOTS),
    .MAX_KEYWORD_LEN (MAX_KEYWORD_LEN),
    .COUNT_WIDTH     (COUNT_WIDTH)
  ) u_matcher (
    .clk           (clk),
    .rst           (rst),
    .fire          (fire),
    .item          (in_item),
    .keyword_count (kcount),
    .kw_byte       (kw_byte),
    .kw_len        (kw_len),
    .rd_addr       (rd_addr),
    .res           (res)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res <= res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {4'b0000, out_res.matched_slot, out_res.count_value};
  assign m_tuser  = out_res.word_matched;

endmodule

### test/kfc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kfc_checker: result checker for the keyword frequency counter
// Watches the configuration, input and result channels. It keeps its own copy
// of the keyword table, counts and word state, works out the result of every
// accepted input transaction and compares each result transaction with the
// oldest expectation, field by field.
// ----------------------------------------------------------------------------
module kfc_checker
  import kfc_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_valid,
  input  logic                cfg_ready,
  input  logic [KCOUNT_W-1:0] cfg_data,
  input  logic                s_tvalid,
  input  logic                s_tready,
  input  logic [15:0]         s_tdata,   // slot[3:0], position[7:4], byte_value[15:8]
  input  logic [CMD_W-1:0]    s_tuser,   // command[1:0]
  input  logic                s_tlast,   // final_char
  input  logic                m_tvalid,
  input  logic                m_tready,
  input  logic [39:0]         m_tdata,   // count_value[31:0], matched_slot[35:32], zero
  input  logic                m_tuser,   // word_matched
  output int                  errors,
  output int                  outstanding,
  output int                  results_checked,
  output int                  match_reports
);

  localparam int SLOTS  = 16;
  localparam int KW_MAX = 16;

  // Shadow copy of the block state.
  logic [BYTE_W-1:0]      kw_byte [SLOTS][KW_MAX];
  logic [LEN_W-1:0]       kw_len [SLOTS];
  logic [COUNT_OUT_W-1:0] slot_count [SLOTS];
  logic [SLOTS-1:0]       alive;
  logic [LEN_W-1:0]       word_len;
  logic [KCOUNT_W-1:0]    slots_in_use;

  result_t expected_results [$];

  // Applies one input transaction to the shadow state and returns its result.
  function automatic result_t apply_command(input item_t it);
    result_t r;
    int      used;
    int      s;
    logic    found;
    r     = '0;
    found = 1'b0;
    used  = (slots_in_use > SLOTS) ? SLOTS : int'(slots_in_use);
    case (it.command)
      CMD_LOAD: begin
        kw_byte[it.slot][it.position] = it.byte_value;
        if (it.final_char) kw_len[it.slot] = {1'b0, it.position} + 5'd1;
      end
      CMD_TEXT: begin
        if (it.byte_value == CHAR_SPACE || it.byte_value == CHAR_NEWLINE) begin
          // A separator closes the word; empty and over-long words credit nothing.
          if (word_len > 0 && word_len <= KW_MAX) begin
            for (s = 0; s < used; s++) begin
              if (!found && alive[s] && kw_len[s] == word_len) begin
                if (slot_count[s] != '1) slot_count[s] = slot_count[s] + COUNT_OUT_W'(1);
                found          = 1'b1;
                r.word_matched = 1'b1;
                r.matched_slot = MSLOT_W'(s);
              end
            end
          end
          alive    = '1;
          word_len = '0;
        end else if (word_len < KW_MAX) begin
          // Each slot stays alive only while its bytes keep agreeing.
          for (s = 0; s < SLOTS; s++) begin
            if (word_len >= kw_len[s] || kw_byte[s][word_len] != it.byte_value)
              alive[s] = 1'b0;
          end
          word_len = word_len + LEN_W'(1);
        end else begin
          alive    = '0;
          word_len = LEN_W'(KW_MAX + 1);
        end
      end
      CMD_READ: begin
        r.count_value = slot_count[it.slot];
      end
      default: begin
        for (s = 0; s < SLOTS; s++) slot_count[s] = '0;
      end
    endcase
    return r;
  endfunction

  always @(posedge clk) begin
    item_t   it;
    result_t pred;
    result_t exp;
    int      s;
    int      p;
    if (rst) begin
      for (s = 0; s < SLOTS; s++) begin
        for (p = 0; p < KW_MAX; p++) kw_byte[s][p] = '0;
        kw_len[s]     = '0;
        slot_count[s] = '0;
      end
      alive        = '1;
      word_len     = '0;
      slots_in_use = '0;
      expected_results.delete();
    end else begin
      // Configuration transaction.
      if (cfg_valid && cfg_ready) slots_in_use = cfg_data;

      // Input transaction: predict its result.
      if (s_tvalid && s_tready) begin
        it.command    = cmd_t'(s_tuser);
        it.slot       = s_tdata[3:0];
        it.position   = s_tdata[7:4];
        it.byte_value = s_tdata[15:8];
        it.final_char = s_tlast;
        pred          = apply_command(it);
        expected_results.insert(expected_results.size(), pred);
      end

      // Result transaction: compare with the oldest expectation.
      if (m_tvalid && m_tready) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with no expectation: count_value %0d, word_matched %0d",
                 m_tdata[31:0], m_tuser);
          errors++;
        end else begin
          exp = expected_results.pop_front();
          results_checked++;
          if (m_tuser) match_reports++;
          if (m_tdata[31:0] !== exp.count_value) begin
            $error("count_value: expected %0d, actual %0d", exp.count_value, m_tdata[31:0]);
            errors++;
          end
          if (m_tuser !== exp.word_matched) begin
            $error("word_matched: expected %0d, actual %0d", exp.word_matched, m_tuser);
            errors++;
          end
          if (m_tdata[35:32] !== exp.matched_slot) begin
            $error("matched_slot: expected %0d, actual %0d", exp.matched_slot, m_tdata[35:32]);
            errors++;
          end
        end
      end
    end
    outstanding <= expected_results.size();
  end

endmodule

### test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the keyword frequency counter unit
// Drives keyword loads, text words, count reads and clears into the block,
// changes the keyword count between bursts of traffic, and lets the checker
// compare every result. Idling on both stream sides varies by phase.
// ----------------------------------------------------------------------------
module tb_top
  import kfc_pkg::*;
;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [KCOUNT_W-1:0] cfg_data = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [15:0]         s_tdata = '0;     // slot[3:0], position[7:4], byte_value[15:8]
  logic [CMD_W-1:0]    s_tuser = '0;     // command[1:0]
  logic                s_tlast = 1'b0;   // final_char
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [39:0]         m_tdata;          // count_value[31:0], matched_slot[35:32], zero
  logic                m_tuser;          // word_matched

  int errors;
  int outstanding;
  int results_checked;
  int match_reports;

  // Idling controls for the sender and the receiver.
  int   send_idle_pct = 18;
  int   recv_idle_pct = 65;

  // What the stimulus side has loaded, so that text can hit the keywords.
  logic [BYTE_W-1:0] kw_text [16][16];
  logic [15:0]       kw_written [16];
  int                kw_len_tb [16];
  int                items_sent;
  int                settings_written;

  always #5 clk = ~clk;

  keyword_frequency_counter_unit uut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  kfc_checker u_checker (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .s_tuser(s_tuser), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .errors(errors), .outstanding(outstanding),
    .results_checked(results_checked), .match_reports(match_reports)
  );

  // Receiver stalls at random at the current idling rate.
  always @(posedge clk) begin
    if (recv_idle_pct == 0) begin
      m_tready <= 1'b1;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  // Random word byte that never splits the word.
  function automatic logic [BYTE_W-1:0] word_char();
    logic [BYTE_W-1:0] b;
    b = BYTE_W'($urandom_range(0, 255));
    if (b == CHAR_SPACE || b == CHAR_NEWLINE) b = 8'h5F;
    return b;
  endfunction

  // Sends one input transaction. A final mark on a load is dropped unless
  // every byte up to that position has been written.
  task automatic push_item(input cmd_t cmd, input logic [SLOT_FW-1:0] slot,
                           input logic [POS_FW-1:0] pos, input logic [BYTE_W-1:0] b,
                           input logic fin);
    logic [15:0] prefix;
    if (cmd == CMD_LOAD) begin
      kw_text[slot][pos]    = b;
      kw_written[slot][pos] = 1'b1;
      prefix = 16'((32'd1 << (pos + 1)) - 1);
      if ((kw_written[slot] & prefix) != prefix) fin = 1'b0;
      if (fin) kw_len_tb[slot] = pos + 1;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {b, pos, slot};
    s_tuser  <= cmd;
    s_tlast  <= fin;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  // Loads a whole keyword in order; src >= 0 copies that slot's keyword.
  task automatic load_keyword(input int slot, input int len, input int src);
    int p;
    for (p = 0; p < len; p++) begin
      push_item(CMD_LOAD, SLOT_FW'(slot), POS_FW'(p),
                (src >= 0) ? kw_text[src][p] : BYTE_W'($urandom_range(0, 255)),
                p == len - 1);
    end
  endtask

  // Sends one text word built from a keyword, then its separator.
  // Modes: 0 exact copy, 1 one bit flipped, 2 one byte shorter or longer,
  // 3 random bytes.
  task automatic stream_word(input int src, input int mode);
    logic [BYTE_W-1:0] w [20];
    int n;
    int k;
    n = kw_len_tb[src];
    if (n == 0) mode = 3;
    for (k = 0; k < n; k++) w[k] = kw_text[src][k];
    case (mode)
      1: begin
        k    = $urandom_range(0, n - 1);
        w[k] = w[k] ^ (8'h01 << $urandom_range(0, 7));
      end
      2: begin
        if (n > 1 && $urandom_range(0, 1) == 1) begin
          n--;
        end else begin
          w[n] = word_char();
          n++;
        end
      end
      3: begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 20) : $urandom_range(1, 8);
        for (k = 0; k < n; k++) w[k] = word_char();
      end
      default: ;
    endcase
    for (k = 0; k < n; k++) begin
      push_item(CMD_TEXT, SLOT_FW'($urandom), POS_FW'($urandom), w[k], 1'($urandom));
    end
    push_item(CMD_TEXT, SLOT_FW'($urandom), POS_FW'($urandom),
              $urandom_range(0, 1) ? CHAR_SPACE : CHAR_NEWLINE, 1'($urandom));
    if ($urandom_range(0, 5) == 0) begin
      push_item(CMD_TEXT, SLOT_FW'($urandom), POS_FW'($urandom), CHAR_SPACE, 1'($urandom));
    end
  endtask

  // Waits until the block has delivered every result, then writes the register.
  task automatic set_keyword_count(input logic [KCOUNT_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (3) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    settings_written++;
  endtask

  // Stimulus.
  initial begin
    logic [KCOUNT_W-1:0] seg_count [6];
    int seg;
    int seg_end;
    int pick;
    int src;
    int k;
    for (k = 0; k < 16; k++) begin
      kw_written[k] = '0;
      kw_len_tb[k]  = 0;
    end
    items_sent       = 0;
    settings_written = 0;
    seg_count[0] = 5'd31;
    seg_count[1] = KCOUNT_W'($urandom_range(1, 15));
    seg_count[2] = 5'd0;
    seg_count[3] = 5'd16;
    seg_count[4] = KCOUNT_W'($urandom_range(1, 15));
    seg_count[5] = KCOUNT_W'($urandom_range(17, 30));

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    set_keyword_count(5'd16);

    // Directed part.
    // One-byte keyword in the top slot, largest byte value.
    push_item(CMD_LOAD, 4'd15, 4'd0, 8'hFF, 1'b1);
    // The same keyword in two slots: only the lower one is credited.
    push_item(CMD_LOAD, 4'd1, 4'd0, 8'h61, 1'b0);
    push_item(CMD_LOAD, 4'd1, 4'd1, 8'h62, 1'b1);
    push_item(CMD_LOAD, 4'd2, 4'd0, 8'h61, 1'b0);
    push_item(CMD_LOAD, 4'd2, 4'd1, 8'h62, 1'b1);
    // Last position of a slot, without setting a length.
    push_item(CMD_LOAD, 4'd4, 4'd15, 8'h00, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, 8'h61, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, 8'h62, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, CHAR_SPACE, 1'b0);
    // Empty words between separators.
    push_item(CMD_TEXT, 4'd0, 4'd0, CHAR_SPACE, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, CHAR_NEWLINE, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, 8'hFF, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, CHAR_NEWLINE, 1'b0);
    // A keyword loaded while a word is in progress.
    push_item(CMD_LOAD, 4'd3, 4'd0, 8'h61, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, 8'h61, 1'b0);
    push_item(CMD_LOAD, 4'd3, 4'd1, 8'h63, 1'b1);
    push_item(CMD_TEXT, 4'd0, 4'd0, 8'h63, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, CHAR_SPACE, 1'b0);
    // Counts cleared in the middle of a word.
    push_item(CMD_TEXT, 4'd0, 4'd0, 8'h61, 1'b0);
    push_item(CMD_CLEAR, 4'd0, 4'd0, 8'h00, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, 8'h62, 1'b0);
    push_item(CMD_TEXT, 4'd0, 4'd0, CHAR_NEWLINE, 1'b0);
    push_item(CMD_READ, 4'd1, 4'd0, 8'h00, 1'b0);
    push_item(CMD_READ, 4'd15, 4'd15, 8'hFF, 1'b1);

    // Random part: six segments, each with its own keyword count.
    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        send_idle_pct <= 65;
        recv_idle_pct <= 18;
      end else if (seg == 4) begin
        send_idle_pct <= 0;
        recv_idle_pct <= 0;
      end
      set_keyword_count(seg_count[seg]);
      seg_end = items_sent + 125;
      while (items_sent < seg_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 12) begin
          load_keyword($urandom_range(0, 15),
                       ($urandom_range(0, 7) == 0) ? $urandom_range(7, 16)
                                                   : $urandom_range(1, 6), -1);
        end else if (pick < 16) begin
          src = $urandom_range(0, 15);
          if (kw_len_tb[src] > 0) load_keyword($urandom_range(0, 15), kw_len_tb[src], src);
        end else if (pick < 70) begin
          k = $urandom_range(0, 19);
          stream_word($urandom_range(0, 15), (k < 10) ? 0 : (k < 13) ? 1 : (k < 16) ? 2 : 3);
        end else if (pick < 82) begin
          push_item(CMD_READ, SLOT_FW'($urandom), POS_FW'($urandom),
                    BYTE_W'($urandom), 1'($urandom));
        end else if (pick < 84) begin
          push_item(CMD_CLEAR, SLOT_FW'($urandom), POS_FW'($urandom),
                    BYTE_W'($urandom), 1'($urandom));
        end else if (pick < 92) begin
          push_item(CMD_LOAD, SLOT_FW'($urandom), POS_FW'($urandom),
                    BYTE_W'($urandom), 1'($urandom));
        end else begin
          push_item(CMD_TEXT, SLOT_FW'($urandom), POS_FW'($urandom),
                    ($urandom_range(0, 3) == 0) ? CHAR_SPACE : BYTE_W'($urandom),
                    1'($urandom));
        end
      end
    end
    // The last line ends with a newline.
    push_item(CMD_TEXT, 4'd0, 4'd0, CHAR_NEWLINE, 1'b0);
    s_tvalid <= 1'b0;

    // Drain the remaining results.
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);

    $display("Covered %0d input transactions under %0d keyword-count settings %s",
             items_sent, settings_written, "in three idling phases.");
    $display("Checked %0d result transactions, %0d of them reporting a keyword match.",
             results_checked, match_reports);
    if (errors == 0 && outstanding == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
